FILE: rtl/core/itc_pkg.sv
package itc_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned DivSteps = DataW;
  localparam int unsigned CntW     = $clog2(DivSteps);

  typedef enum logic [2:0] {
    OP_NUMBER = 3'd0,
    OP_PLUS   = 3'd1,
    OP_MINUS  = 3'd2,
    OP_TIMES  = 3'd3,
    OP_DIVIDE = 3'd4,
    OP_EQUALS = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    MUL_NONE   = 2'd0,
    MUL_TIMES  = 2'd1,
    MUL_DIVIDE = 2'd2
  } mul_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DIV0  = 2'd1,
    ST_ORDER = 2'd2
  } status_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_num;   // product term takes the token's number
    logic mul;        // product term times the token's number
    logic div_zero;   // zero divisor, product term becomes zero
    logic div_start;  // load the divider from product term and number
    logic div_step;   // one quotient bit
    logic div_fix;    // apply the quotient sign into the product term
    logic add_finish; // fold the product term into the running sum
    logic sub;        // pending additive operator is minus
    logic load_out;   // capture the finished sum into the result register
    logic clear;      // back to a fresh expression
  } dp_cmd_t;

  typedef struct packed {
    logic divisor_zero;
    logic div_last;
  } dp_stat_t;

endpackage

FILE: rtl/core/itc_tok_if.sv
interface itc_tok_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic signed [31:0] number;

  modport source (output valid, output opcode, output number, input ready);
  modport sink (input valid, input opcode, input number, output ready);
endinterface

interface itc_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

FILE: rtl/core/itc_datapath.sv
module itc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  itc_pkg::dp_cmd_t    cmd_i,
  input  logic signed [31:0]  number_i,
  output itc_pkg::dp_stat_t   stat_o,
  output logic signed [31:0]  value_o
);
  import itc_pkg::*;

  logic [DataW-1:0] sum_q, sum_d;
  logic [DataW-1:0] prod_q, prod_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [DataW-1:0] dvs_q, dvs_d;
  logic             neg_q, neg_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] value_q, value_d;

  logic [DataW-1:0] num;
  logic [DataW-1:0] finish_sum;
  logic [DataW-1:0] mul_res;
  logic [DataW:0]   trial;

  assign num        = DataW'(number_i);
  assign finish_sum = cmd_i.sub ? (sum_q - prod_q) : (sum_q + prod_q);
  assign mul_res    = prod_q * num;
  // restoring step on magnitudes, remainder stays below the divisor
  assign trial      = {rem_q, quo_q[DataW-1]} - {1'b0, dvs_q};

  always_comb begin
    sum_d   = sum_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    value_d = value_q;
    if (cmd_i.load_num) prod_d = num;
    if (cmd_i.mul)      prod_d = mul_res;
    if (cmd_i.div_zero) prod_d = '0;
    if (cmd_i.div_start) begin
      rem_d = '0;
      quo_d = prod_q[DataW-1] ? (DataW'(0) - prod_q) : prod_q;
      dvs_d = num[DataW-1] ? (DataW'(0) - num) : num;
      neg_d = prod_q[DataW-1] ^ num[DataW-1];
      cnt_d = '0;
    end
    if (cmd_i.div_step) begin
      if (!trial[DataW]) begin
        rem_d = trial[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DataW-2:0], quo_q[DataW-1]};
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
      cnt_d = cnt_q + CntW'(1);
    end
    if (cmd_i.div_fix) prod_d = neg_q ? (DataW'(0) - quo_q) : quo_q;
    if (cmd_i.add_finish) begin
      sum_d  = finish_sum;
      prod_d = '0;
    end
    if (cmd_i.load_out) value_d = finish_sum;
    if (cmd_i.clear) begin
      sum_d  = '0;
      prod_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      prod_q <= '0;
    end else begin
      sum_q  <= sum_d;
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    dvs_q   <= dvs_d;
    neg_q   <= neg_d;
    cnt_q   <= cnt_d;
    value_q <= value_d;
  end

  assign stat_o.divisor_zero = (num == '0);
  assign stat_o.div_last     = (cnt_q == CntW'(DivSteps - 1));
  assign value_o             = value_q;

endmodule

FILE: rtl/core/itc_ctrl.sv
module itc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [2:0]        opcode_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output itc_pkg::dp_cmd_t  cmd_o,
  input  itc_pkg::dp_stat_t stat_i
);
  import itc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_FIX  = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e   state_q, state_d;
  logic     add_q, add_d;
  mul_op_e  mul_q, mul_d;
  logic     expect_q, expect_d;
  status_e  sticky_q, sticky_d;
  logic     oval_q, oval_d;
  status_e  ostat_q, ostat_d;

  logic     fire;
  logic     out_free;
  dp_cmd_t  cmd;
  logic     raise_order;
  logic     raise_div0;
  logic     emit;

  assign in_ready_o = (state_q == S_IDLE);
  assign fire       = in_valid_i && in_ready_o;
  assign out_free   = !oval_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    add_d       = add_q;
    mul_d       = mul_q;
    expect_d    = expect_q;
    cmd         = '0;
    raise_order = 1'b0;
    raise_div0  = 1'b0;
    emit        = 1'b0;
    cmd.sub     = add_q;

    unique case (state_q)
      S_IDLE: begin
        if (fire) begin
          unique case (opcode_i) inside
            OP_NUMBER: begin
              if (!expect_q) begin
                raise_order = 1'b1;
              end else begin
                case (mul_q)
                  MUL_TIMES: cmd.mul = 1'b1;
                  MUL_DIVIDE: begin
                    if (stat_i.divisor_zero) begin
                      cmd.div_zero = 1'b1;
                      raise_div0   = 1'b1;
                    end else begin
                      cmd.div_start = 1'b1;
                      state_d       = S_DIV;
                    end
                  end
                  default: cmd.load_num = 1'b1;
                endcase
                mul_d    = MUL_NONE;
                expect_d = 1'b0;
              end
            end
            OP_PLUS, OP_MINUS, OP_TIMES, OP_DIVIDE, OP_EQUALS: begin
              if (expect_q) begin
                raise_order = 1'b1;
              end else begin
                case (opcode_i) inside
                  OP_PLUS, OP_MINUS: begin
                    cmd.add_finish = 1'b1;
                    add_d          = (opcode_i == OP_MINUS);
                    mul_d          = MUL_NONE;
                    expect_d       = 1'b1;
                  end
                  OP_TIMES: begin
                    mul_d    = MUL_TIMES;
                    expect_d = 1'b1;
                  end
                  OP_DIVIDE: begin
                    mul_d    = MUL_DIVIDE;
                    expect_d = 1'b1;
                  end
                  default: begin
                    if (out_free) emit = 1'b1;
                    else state_d = S_EMIT;
                  end
                endcase
              end
            end
            default: raise_order = 1'b1;
          endcase
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_FIX;
      end
      S_FIX: begin
        cmd.div_fix = 1'b1;
        state_d     = S_IDLE;
      end
      S_EMIT: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (emit) begin
      cmd.load_out = 1'b1;
      cmd.clear    = 1'b1;
      add_d        = 1'b0;
      mul_d        = MUL_NONE;
      expect_d     = 1'b1;
    end
  end

  // order error outranks a division error
  always_comb begin
    sticky_d = sticky_q;
    if (raise_order) sticky_d = ST_ORDER;
    else if (raise_div0 && (sticky_q == ST_OK)) sticky_d = ST_DIV0;
    if (emit) sticky_d = ST_OK;
  end

  always_comb begin
    oval_d  = oval_q;
    ostat_d = ostat_q;
    if (oval_q && out_ready_i) oval_d = 1'b0;
    if (emit) begin
      oval_d  = 1'b1;
      ostat_d = sticky_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      add_q    <= 1'b0;
      mul_q    <= MUL_NONE;
      expect_q <= 1'b1;
      sticky_q <= ST_OK;
      oval_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      add_q    <= add_d;
      mul_q    <= mul_d;
      expect_q <= expect_d;
      sticky_q <= sticky_d;
      oval_q   <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ostat_q <= ostat_d;
  end

  assign out_valid_o = oval_q;
  assign status_o    = ostat_q;
  assign cmd_o       = cmd;

endmodule

FILE: rtl/core/infix_token_calculator.sv
// infix calculator over a stream of lexed tokens: numbers and + - * / =, with * and /
// binding tighter than + and -; '=' emits the wrapped 32-bit value and a status
// (0 ok, 1 division by zero, 2 token order error) and starts a fresh expression.
// a token is taken whenever the calculator is idle; a nonzero number that follows '/'
// first loads the divider, then runs the shared one-bit-per-cycle restoring divider,
// then applies the sign, and no new token is taken until that is done. the result sits
// in an output register, so tokens keep flowing while it waits; an '=' that finds that
// register still full is taken, but the next token holds until the register drains.
module infix_token_calculator (
  input  logic      clk_i,
  input  logic      rst_ni,
  itc_tok_if.sink   tok_i,
  itc_res_if.source res_o
);
  import itc_pkg::*;

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic signed [31:0] value;

  itc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tok_i.valid),
    .opcode_i    (tok_i.opcode),
    .in_ready_o  (tok_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .status_o    (res_o.status),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  itc_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .number_i (tok_i.number),
    .stat_o   (stat),
    .value_o  (value)
  );

  assign res_o.value = value;

endmodule
